@@ rtl/core/rolling_hash_substring_search_assert.svh @@
// Assertion macros shared by the rolling hash search RTL.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef ROLLING_HASH_SUBSTRING_SEARCH_ASSERT_SVH
`define ROLLING_HASH_SUBSTRING_SEARCH_ASSERT_SVH

// same-cycle implication
`define RHSS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RHSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// invariant
`define RHSS_ASSERT_ALWAYS(label, cond, msg) \
	`RHSS_ASSERT_IMPL(label, 1'b1, cond, msg)

`endif

@@ rtl/core/rhss_pkg.sv @@
// Package for the rolling hash substring search: sizes, beat types,
// sequencer states and the mod-997 fold. No dependencies.
package rhss_pkg;

	localparam int PATTERN_MAX = 16;
	localparam int TEXT_MAX    = 65536;
	localparam int IDX_W       = 4;
	localparam int LEN_W       = 5;
	localparam int POS_W       = 16;
	localparam int HASH_W      = 10;
	localparam int BYTE_W      = 8;
	localparam int CNT_W       = 4;

	localparam logic [HASH_W-1:0] HASH_MOD   = HASH_W'(997);
	localparam logic [BYTE_W-1:0] HASH_BASE  = BYTE_W'(26);
	localparam logic [POS_W-1:0]  COUNT_LIMIT = POS_W'(TEXT_MAX - 1);
	localparam logic [CNT_W-1:0]  MUL_STEPS  = CNT_W'(BYTE_W);
	localparam logic [LEN_W-1:0]  LEN_MAX    = LEN_W'(PATTERN_MAX);

	typedef enum logic {
		REQ_PATTERN = 1'b0,
		REQ_TEXT    = 1'b1
	} req_t;

	typedef struct packed {
		logic              req_type;
		logic [IDX_W-1:0]  pattern_index;
		logic [BYTE_W-1:0] byte_value;
		logic              end_of_text;
	} in_item_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] match_position;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic [HASH_W-1:0] a;
		logic [BYTE_W-1:0] m;
		logic [HASH_W-1:0] add;
	} mm_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [HASH_W-1:0] result;
	} mm_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PH,
		ST_LP,
		ST_DROP,
		ST_ROLL,
		ST_CMP,
		ST_EMIT
	} state_t;

	// reduce a value below 2*HASH_MOD
	function automatic logic [HASH_W-1:0] mod_fold(input logic [HASH_W:0] s);
		logic [HASH_W:0] m;
		m = {1'b0, HASH_MOD};
		return (s >= m) ? HASH_W'(s - m) : s[HASH_W-1:0];
	endfunction

endpackage

@@ rtl/core/rolling_hash_substring_search.sv @@
// Pattern byte at index 0 is stored directly; other pattern bytes take two multiplier passes.
// Text byte: one pass before the window fills, two after (drop, then roll), through the shared
// shift-add mod-997 multiplier. A hash hit adds a byte-by-byte compare of up to len_eff
// bytes; a result goes through ST_EMIT into the output register. One byte at a time.
// arst_n clears control, hashes, count and window ring; pattern store is not cleared.
// Depends on rhss_pkg, rhss_mulmod and rolling_hash_substring_search_assert.svh.
`include "rolling_hash_substring_search_assert.svh"

module rolling_hash_substring_search import rhss_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_wr_en,
	input  logic [LEN_W-1:0] cfg_wr_data
);

	state_t            state_q, state_d;
	mm_req_t           mm_req;
	mm_rsp_t           mm_rsp;

	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  len_eff;
	logic [IDX_W-1:0]  lenm1;
	logic [BYTE_W-1:0] pat_q  [PATTERN_MAX];
	logic [BYTE_W-1:0] ring_q [PATTERN_MAX];
	logic [HASH_W-1:0] ph_q;
	logic [HASH_W-1:0] lp_q;
	logic [HASH_W-1:0] wh_q;
	logic [POS_W-1:0]  tc_q;
	logic              md_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic [IDX_W-1:0]  j_q;
	logic              res_found_q;
	logic [POS_W-1:0]  res_pos_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              acc_in, pat_acc, txt_acc;
	logic              roll_fin, hash_ok, cmp_eq, cmp_hit, cmp_miss;
	logic              restart, emit_load, need_drop;
	logic [IDX_W-1:0]  rd_idx;
	logic [BYTE_W-1:0] ring_rd, pat_rd;
	logic [HASH_W-1:0] wh_sub;
	logic [POS_W-1:0]  start_pos;

	rhss_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.rsp    (mm_rsp)
	);

	always_comb begin
		if (len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (len_q > LEN_MAX) begin
			len_eff = LEN_MAX;
		end else begin
			len_eff = len_q;
		end
		lenm1 = IDX_W'(len_eff - LEN_W'(1));
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign acc_in    = in_valid && in_ready;
	assign pat_acc   = acc_in && (in_data.req_type == REQ_PATTERN);
	assign txt_acc   = acc_in && (in_data.req_type == REQ_TEXT);
	assign need_drop = tc_q >= POS_W'(len_eff);

	assign rd_idx  = (state_q == ST_CMP) ? IDX_W'(lenm1 - j_q) : lenm1;
	assign ring_rd = ring_q[rd_idx];
	assign pat_rd  = pat_q[j_q];

	assign wh_sub = (wh_q >= mm_rsp.result) ? HASH_W'(wh_q - mm_rsp.result)
		: HASH_W'({1'b0, wh_q} + {1'b0, HASH_MOD} - {1'b0, mm_rsp.result});
	assign start_pos = POS_W'(tc_q + POS_W'(1) - POS_W'(len_eff));

	assign roll_fin  = (state_q == ST_ROLL) && mm_rsp.done;
	assign hash_ok   = (tc_q >= POS_W'(lenm1)) && (mm_rsp.result == ph_q);
	assign cmp_eq    = (ring_rd == pat_rd);
	assign cmp_hit   = (state_q == ST_CMP) && cmp_eq && (j_q == lenm1);
	assign cmp_miss  = (state_q == ST_CMP) && !cmp_eq;
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign restart   = cfg_wr_en || pat_acc
		|| (txt_acc && md_q && in_data.end_of_text)
		|| (roll_fin && !hash_ok && last_q)
		|| ((cmp_hit || cmp_miss) && last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		mm_req     = '0;
		mm_req.a   = wh_q;
		mm_req.m   = HASH_BASE;
		mm_req.add = HASH_W'(byte_q);
		unique case (state_q)
			ST_IDLE: begin
				if (pat_acc && (in_data.pattern_index != '0)) begin
					mm_req.start = 1'b1;
					mm_req.a     = ph_q;
					mm_req.add   = HASH_W'(in_data.byte_value);
					state_d      = ST_PH;
				end else if (txt_acc && !md_q) begin
					mm_req.start = 1'b1;
					if (need_drop) begin
						mm_req.a   = lp_q;
						mm_req.m   = ring_rd;
						mm_req.add = '0;
						state_d    = ST_DROP;
					end else begin
						mm_req.add = HASH_W'(in_data.byte_value);
						state_d    = ST_ROLL;
					end
				end
			end
			ST_PH: begin
				if (mm_rsp.done) begin
					mm_req.start = 1'b1;
					mm_req.a     = lp_q;
					mm_req.add   = '0;
					state_d      = ST_LP;
				end
			end
			ST_LP: begin
				if (mm_rsp.done) begin
					state_d = ST_IDLE;
				end
			end
			ST_DROP: begin
				if (mm_rsp.done) begin
					mm_req.start = 1'b1;
					mm_req.a     = wh_sub;
					state_d      = ST_ROLL;
				end
			end
			ST_ROLL: begin
				if (mm_rsp.done) begin
					if (hash_ok) begin
						state_d = ST_CMP;
					end else if (last_q) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_CMP: begin
				if (cmp_hit) begin
					state_d = ST_EMIT;
				end else if (cmp_miss) begin
					state_d = last_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (emit_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= LEN_W'(1);
			ph_q        <= '0;
			lp_q        <= HASH_W'(1);
			wh_q        <= '0;
			tc_q        <= '0;
			md_q        <= 1'b0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < PATTERN_MAX; k++) begin
				ring_q[k] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				len_q <= cfg_wr_data;
			end
			if (pat_acc && (in_data.pattern_index == '0)) begin
				ph_q <= HASH_W'(in_data.byte_value);
				lp_q <= HASH_W'(1);
			end
			if ((state_q == ST_PH) && mm_rsp.done) begin
				ph_q <= mm_rsp.result;
			end
			if ((state_q == ST_LP) && mm_rsp.done) begin
				lp_q <= mm_rsp.result;
			end
			if ((state_q == ST_DROP) && mm_rsp.done) begin
				wh_q <= wh_sub;
			end
			if (roll_fin) begin
				wh_q <= mm_rsp.result;
				for (int k = PATTERN_MAX - 1; k > 0; k--) begin
					ring_q[k] <= ring_q[k-1];
				end
				ring_q[0] <= byte_q;
				if (tc_q < COUNT_LIMIT) begin
					tc_q <= tc_q + POS_W'(1);
				end
				j_q <= '0;
			end
			if ((state_q == ST_CMP) && cmp_eq && !cmp_hit) begin
				j_q <= j_q + IDX_W'(1);
			end
			if (cmp_hit) begin
				md_q <= 1'b1;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end
			if (restart) begin
				wh_q <= '0;
				tc_q <= '0;
				md_q <= 1'b0;
				for (int k = 0; k < PATTERN_MAX; k++) begin
					ring_q[k] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pat_acc) begin
			pat_q[in_data.pattern_index] <= in_data.byte_value;
		end
		if (txt_acc) begin
			byte_q <= in_data.byte_value;
			last_q <= in_data.end_of_text;
		end
		if (roll_fin) begin
			res_found_q <= 1'b0;
			res_pos_q   <= hash_ok ? start_pos : '0;
		end
		if (cmp_miss) begin
			res_pos_q <= '0;
		end
		if (cmp_hit) begin
			res_found_q <= 1'b1;
		end
		if (emit_load) begin
			out_q.found          <= res_found_q;
			out_q.match_position <= res_pos_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`RHSS_ASSERT_ALWAYS(a_hash_reduced, (wh_q < HASH_MOD) && (ph_q < HASH_MOD) && (lp_q < HASH_MOD), "hash state not reduced")
	`RHSS_ASSERT_IMPL(a_idle_unit_free, state_q == ST_IDLE, !mm_rsp.busy, "multiplier busy while idle")
	`RHSS_ASSERT_IMPL(a_notfound_zero, out_valid_q && !out_q.found, out_q.match_position == '0, "not-found beat with nonzero position")
	`RHSS_ASSERT_NEXT(a_emit_shows, emit_load, out_valid_q, "result beat not presented")

endmodule

@@ rtl/core/rhss_mulmod.sv @@
// Shared shift-add multiplier mod 997: (a*m + add) mod 997, one bit of m per cycle.
// Depends on rhss_pkg and rolling_hash_substring_search_assert.svh.
`include "rolling_hash_substring_search_assert.svh"

module rhss_mulmod import rhss_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  mm_req_t req,
	output mm_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [HASH_W-1:0] a_q;
	logic [BYTE_W-1:0] m_q;
	logic [HASH_W-1:0] add_q;
	logic [HASH_W-1:0] acc_q;
	logic [HASH_W-1:0] dbl;
	logic [HASH_W-1:0] addend;
	logic [HASH_W-1:0] step_v;
	logic [HASH_W-1:0] fin_v;

	always_comb begin
		dbl    = mod_fold({acc_q, 1'b0});
		addend = m_q[BYTE_W-1] ? a_q : '0;
		step_v = mod_fold({1'b0, dbl} + {1'b0, addend});
		fin_v  = mod_fold({1'b0, acc_q} + {1'b0, add_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				acc_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == MUL_STEPS) begin
					acc_q  <= fin_v;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					acc_q <= step_v;
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			m_q   <= req.m;
			add_q <= req.add;
		end else if (busy_q) begin
			m_q <= {m_q[BYTE_W-2:0], 1'b0};
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.result = acc_q;

	`RHSS_ASSERT_IMPL(a_no_start_busy, req.start, !busy_q, "start while unit busy")
	`RHSS_ASSERT_IMPL(a_done_reduced, done_q, acc_q < HASH_MOD, "result not reduced")
	`RHSS_ASSERT_IMPL(a_cnt_bound, busy_q, cnt_q <= MUL_STEPS, "step count overrun")

endmodule

@@ dv/rolling_hash_substring_search_checker.sv @@
// Checker for the rolling hash substring search: watches the input, output and
// length-register ports, predicts each result beat and compares it on arrival.
// Depends on rhss_pkg.
module rolling_hash_substring_search_checker import rhss_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  in_item_t         in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  out_item_t        out_data,
	input  logic             cfg_wr_en,
	input  logic [LEN_W-1:0] cfg_wr_data,
	output int               fail_count,
	output int               pending,
	output int               items_used,
	output int               found_count,
	output int               miss_count
);

	localparam int MOD  = 997;
	localparam int BASE = 26;

	logic [BYTE_W-1:0] needle_mem [PATTERN_MAX];
	logic [BYTE_W-1:0] window [PATTERN_MAX];
	logic [HASH_W-1:0] needle_hash;
	logic [HASH_W-1:0] window_hash;
	logic [HASH_W-1:0] lead_power;
	logic [POS_W-1:0]  text_count;
	logic [LEN_W-1:0]  len_reg;
	bit                match_done;
	out_item_t         result_q[$];
	int                n_fail, n_used, n_found, n_miss;

	function automatic int search_len();
		if (len_reg == 0) return 1;
		if (len_reg > PATTERN_MAX) return PATTERN_MAX;
		return int'(len_reg);
	endfunction

	task automatic clear_search();
		foreach (window[k]) window[k] = '0;
		window_hash = '0;
		text_count  = '0;
		match_done  = 1'b0;
	endtask

	task automatic note_miss(input string what, input out_item_t want, input out_item_t got);
		n_fail++;
		if (n_fail <= 10)
			$display("%s: expected found=%0d pos=%0d, got found=%0d pos=%0d", what,
				want.found, want.match_position, got.found, got.match_position);
	endtask

	task automatic take_beat(input in_item_t it);
		int len, drop, h, start, k;
		bit same, hit;
		out_item_t res;
		len   = search_len();
		hit   = 1'b0;
		start = 0;
		n_used++;
		if (it.req_type == REQ_PATTERN) begin
			needle_mem[it.pattern_index] = it.byte_value;
			if (it.pattern_index == 0) begin
				needle_hash = HASH_W'(int'(it.byte_value) % MOD);
				lead_power  = HASH_W'(1);
			end else begin
				needle_hash = HASH_W'((int'(needle_hash) * BASE + int'(it.byte_value)) % MOD);
				lead_power  = HASH_W'((int'(lead_power) * BASE) % MOD);
			end
			clear_search();
		end else if (!match_done) begin
			h = int'(window_hash);
			if (int'(text_count) >= len) begin
				drop = (int'(window[len-1]) * int'(lead_power)) % MOD;
				h = (h + MOD - drop) % MOD;
			end
			h = (h * BASE + int'(it.byte_value)) % MOD;
			window_hash = HASH_W'(h);
			for (k = PATTERN_MAX - 1; k > 0; k--)
				window[k] = window[k-1];
			window[0] = it.byte_value;
			if (int'(text_count) + 1 >= len && h == int'(needle_hash)) begin
				same = 1'b1;
				for (k = 0; k < len; k++)
					if (window[len-1-k] != needle_mem[k]) same = 1'b0;
				if (same) begin
					hit        = 1'b1;
					start      = int'(text_count) + 1 - len;
					match_done = 1'b1;
				end
			end
			if (text_count < COUNT_LIMIT) text_count++;
			if (hit || it.end_of_text) begin
				res.found          = hit;
				res.match_position = POS_W'(start);
				result_q.push_back(res);
				if (it.end_of_text) clear_search();
			end
		end else if (it.end_of_text) begin
			clear_search();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			foreach (needle_mem[k]) needle_mem[k] = '0;
			needle_hash = '0;
			lead_power  = HASH_W'(1);
			len_reg     = LEN_W'(1);
			clear_search();
			result_q.delete();
			n_fail  = 0;
			n_used  = 0;
			n_found = 0;
			n_miss  = 0;
			fail_count  <= 0;
			pending     <= 0;
			items_used  <= 0;
			found_count <= 0;
			miss_count  <= 0;
		end else begin
			if (cfg_wr_en) begin
				len_reg = cfg_wr_data;
				clear_search();
			end
			if (in_valid && in_ready) take_beat(in_data);
			if (out_valid && out_ready) begin
				if (out_data.found) n_found++;
				else n_miss++;
				if (result_q.size() == 0) begin
					note_miss("result beat with none expected", '0, out_data);
				end else begin
					want = result_q.pop_front();
					if (want.found !== out_data.found ||
						want.match_position !== out_data.match_position)
						note_miss("result mismatch", want, out_data);
				end
			end
			fail_count  <= n_fail;
			pending     <= result_q.size();
			items_used  <= n_used;
			found_count <= n_found;
			miss_count  <= n_miss;
		end
	end

endmodule

@@ dv/rolling_hash_substring_search_tb.sv @@
// Top of the rolling hash substring search bench: clock, reset, pattern and text
// stimulus with bursty input and stalling output, and the final verdict.
// Depends on rhss_pkg, the search block and rolling_hash_substring_search_checker.
module rolling_hash_substring_search_tb;
	import rhss_pkg::*;

	localparam int ITEM_GOAL     = 1450;
	localparam int SETTLE_CYCLES = 60;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             in_valid    = 1'b0;
	logic             in_ready;
	in_item_t         in_data     = '0;
	logic             out_valid;
	logic             out_ready   = 1'b0;
	out_item_t        out_data;
	logic             cfg_wr_en   = 1'b0;
	logic [LEN_W-1:0] cfg_wr_data = '0;

	int fail_count, pending, items_used, found_count, miss_count;

	logic [BYTE_W-1:0] needle [PATTERN_MAX];
	logic [BYTE_W-1:0] text_q[$];
	int needle_len;
	int search_len;
	int burst_left = 0;
	int stall_left;
	int stall_mode;
	int phase_count = 0;

	rolling_hash_substring_search dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	rolling_hash_substring_search_checker search_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.fail_count (fail_count),
		.pending    (pending),
		.items_used (items_used),
		.found_count(found_count),
		.miss_count (miss_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: modes of always ready, random, mostly stalled, fully stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
			stall_mode <= 0;
		end else if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(5, 60);
		end else begin
			stall_left <= stall_left - 1;
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 7) == 0);
				default: out_ready <= 1'b0;
			endcase
		end
	end

	function automatic logic [BYTE_W-1:0] pick_byte(input int alpha);
		case (alpha)
			0: return BYTE_W'($urandom_range(0, 255));
			1: return BYTE_W'($urandom_range(8'h61, 8'h63));
			default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		endcase
	endfunction

	task automatic push_beat(input req_t req, input logic [IDX_W-1:0] idx,
		input logic [BYTE_W-1:0] b, input logic eot);
		in_item_t it;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 25);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) :
				$urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		it.req_type      = req;
		it.pattern_index = idx;
		it.byte_value    = b;
		it.end_of_text   = eot;
		in_data  <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_needle(input int n);
		int k;
		for (k = 0; k < n; k++) push_beat(REQ_PATTERN, IDX_W'(k), needle[k], 1'b0);
		needle_len = n;
	endtask

	task automatic send_text(input bit with_end);
		int k;
		for (k = 0; k < text_q.size(); k++)
			push_beat(REQ_TEXT, IDX_W'($urandom), text_q[k],
				with_end && (k == text_q.size() - 1));
	endtask

	// random lead-in, then a copy of the pattern, a same-hash near miss or neither, then a tail
	task automatic build_text(input int alpha);
		int n, k, sel, pos;
		text_q.delete();
		n = $urandom_range(0, 12);
		repeat (n) text_q.push_back(pick_byte(alpha));
		sel = $urandom_range(0, 9);
		if (sel < 6) begin
			for (k = 0; k < needle_len; k++) text_q.push_back(needle[k]);
		end else if (sel < 8) begin
			pos = -1;
			for (k = 0; k + 1 < needle_len; k++)
				if (pos < 0 && needle[k] != 8'hFF && needle[k+1] >= 26) pos = k;
			if (pos >= 0)
				for (k = 0; k < needle_len; k++)
					text_q.push_back(k == pos ? needle[k] + 8'd1 :
						k == pos + 1 ? needle[k] - 8'd26 : needle[k]);
		end
		n = $urandom_range(0, 8);
		repeat (n) text_q.push_back(pick_byte(alpha));
		if (text_q.size() == 0) text_q.push_back(pick_byte(alpha));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_len(input int v);
		settle();
		cfg_wr_data <= LEN_W'(v);
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		search_len = (v == 0) ? 1 : (v > PATTERN_MAX ? PATTERN_MAX : v);
	endtask

	initial begin
		int k, v, sel, alpha, n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every pattern entry once so no search compares an unwritten one
		write_len(16);
		for (k = 0; k < PATTERN_MAX; k++) needle[k] = pick_byte(0);
		needle[0]  = 8'h00;
		needle[15] = 8'hFF;
		send_needle(16);

		write_len(0);
		needle[0] = 8'hFF;
		send_needle(1);
		text_q = '{8'h00, 8'hFF, 8'h12};
		send_text(1);
		write_len(1);
		text_q = '{8'hFF};
		send_text(1);
		write_len(3);
		needle[0] = 8'h0A;
		needle[1] = 8'h28;
		needle[2] = 8'h00;
		send_needle(3);
		// equal hash without a match, then a match ending on the last byte
		text_q = '{8'h0B, 8'h0E, 8'h00, 8'h0A, 8'h28, 8'h00};
		send_text(1);
		text_q = '{8'h0A, 8'h28};
		send_text(1);
		write_len(31);
		text_q = '{8'h0A};
		send_text(1);
		write_len(17);

		while (items_used < ITEM_GOAL) begin
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 4))
					0: v = 0;
					1: v = 1;
					2: v = 16;
					3: v = 17;
					default: v = 31;
				endcase
			end else begin
				v = $urandom_range(1, PATTERN_MAX);
			end
			write_len(v);
			repeat ($urandom_range(2, 6)) begin
				sel   = $urandom_range(0, 9);
				alpha = $urandom_range(0, 2);
				if (sel < 8) begin
					n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, PATTERN_MAX) :
						search_len;
					for (k = 0; k < n; k++) needle[k] = pick_byte(alpha);
					send_needle(n);
					repeat ($urandom_range(1, 3)) begin
						build_text(alpha);
						send_text(1);
					end
				end else if (sel == 8) begin
					repeat ($urandom_range(1, 6))
						push_beat(req_t'($urandom_range(0, 1)), IDX_W'($urandom),
							BYTE_W'($urandom), 1'($urandom_range(0, 1)));
				end else begin
					// text left open; the next pattern load restarts the search
					build_text(alpha);
					send_text(0);
				end
			end
			phase_count++;
		end

		settle();
		$display("%0d length settings, %0d beats searched or loaded",
			phase_count + 6, items_used);
		$display("%0d searches reported a match, %0d ended without one",
			found_count, miss_count);
		if (pending != 0) $display("%0d expected results never arrived", pending);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
